/* rtl/dbpe_pkg.sv */
package dbpe_pkg;

   localparam int COLUMNS     = 1024;
   localparam int ROW_LIMIT   = 2048;
   localparam int ENTRIES     = 3 * COLUMNS;
   localparam int ADDR_W      = $clog2(ENTRIES);

   localparam int BAND_PERIOD = 23;
   localparam int THRESHOLD   = 128;
   localparam int FULL_SCALE  = 256;

   localparam int ERR_W       = 9;
   localparam int BAND_W      = 24;
   localparam int SUM_W       = 11;
   localparam int WORD_W      = ERR_W + BAND_W;

   localparam int MOD_SHIFT   = 16;
   localparam int MOD_MUL     = (1 << MOD_SHIFT) / BAND_PERIOD + 1;

   localparam logic [1:0] PRI_YELLOW  = 2'd0;
   localparam logic [1:0] PRI_MAGENTA = 2'd1;
   localparam logic [1:0] PRI_CYAN    = 2'd2;

   localparam logic [7:0] BYTE_ESC = 8'h1B;
   localparam logic [7:0] BYTE_EM  = 8'h19;
   localparam logic [7:0] BYTE_PCT = 8'h25;
   localparam logic [7:0] BYTE_O   = 8'h4F;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;

   // byte slots of one request, in emit order
   localparam int SEQ_LEN = 12;
   localparam logic [3:0] SEQ_INIT_ESC = 4'd0;
   localparam logic [3:0] SEQ_INIT_EM  = 4'd1;
   localparam logic [3:0] SEQ_GFX_ESC  = 4'd2;
   localparam logic [3:0] SEQ_GFX_PCT  = 4'd3;
   localparam logic [3:0] SEQ_GFX_O    = 4'd4;
   localparam logic [3:0] SEQ_LEN_LO   = 4'd5;
   localparam logic [3:0] SEQ_LEN_HI   = 4'd6;
   localparam logic [3:0] SEQ_BAND_HI  = 4'd7;
   localparam logic [3:0] SEQ_BAND_MID = 4'd8;
   localparam logic [3:0] SEQ_BAND_LO  = 4'd9;
   localparam logic [3:0] SEQ_CR       = 4'd10;
   localparam logic [3:0] SEQ_LF       = 4'd11;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ERR_W-1:0]  err;
      logic [BAND_W-1:0] band;
   } store_write_type;

   typedef struct packed {
      logic [SEQ_LEN-1:0] mask;
      logic [10:0]        len;
      logic [BAND_W-1:0]  band;
   } emit_load_type;

endpackage

/* rtl/dbpe_store.sv */
module dbpe_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [dbpe_pkg::ADDR_W-1:0]    rd_addr,
   input  dbpe_pkg::store_write_type      wr,
   output logic                           ready,
   output logic [dbpe_pkg::ERR_W-1:0]     rd_err,
   output logic [dbpe_pkg::BAND_W-1:0]    rd_band
);
   import dbpe_pkg::*;

   logic [WORD_W-1:0] mem [ENTRIES];

   logic [WORD_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   store_write_type   last_wr_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              clearing_ff;

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= {wr.err, wr.band};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // clearing pass and write forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clr_cnt_ff     <= '0;
         last_wr_ff.en  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(ENTRIES - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (!clearing_ff && wr.en) begin
            last_wr_ff.en <= 1'b1;
         end
      end
      if (!clearing_ff && wr.en) begin
         last_wr_ff.addr <= wr.addr;
         last_wr_ff.err  <= wr.err;
         last_wr_ff.band <= wr.band;
      end
   end

   always_comb begin
      if (last_wr_ff.en && last_wr_ff.addr == rd_addr_ff) begin
         rd_err  = last_wr_ff.err;
         rd_band = last_wr_ff.band;
      end else begin
         rd_err  = rd_data_ff[WORD_W-1:BAND_W];
         rd_band = rd_data_ff[BAND_W-1:0];
      end
   end

   assign ready = !clearing_ff;

endmodule

/* rtl/dbpe_diffuse.sv */
module dbpe_diffuse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  logic [1:0]                    req_primary,
   input  logic [9:0]                    req_column,
   input  logic [7:0]                    req_intensity,
   input  logic [10:0]                   req_row,
   input  logic [10:0]                   req_line_length,
   input  logic [dbpe_pkg::ERR_W-1:0]    rd_err,
   input  logic [dbpe_pkg::BAND_W-1:0]   rd_band,
   input  logic                          emit_free,
   output logic [dbpe_pkg::ADDR_W-1:0]   rd_addr,
   output logic                          hold,
   output dbpe_pkg::store_write_type     wr,
   output logic                          emit_load,
   output dbpe_pkg::emit_load_type       emit_data
);
   import dbpe_pkg::*;

   // request decode
   logic              req_skip;
   logic [22:0]       mod_prod;
   logic [6:0]        mod_quot;
   logic [10:0]       mod_rem;
   logic [10:0]       mod_fix;
   int                base;

   always_comb begin
      req_skip = (req_primary > PRI_CYAN) || (int'(req_column) >= COLUMNS)
         || (int'(req_row) >= ROW_LIMIT);
      case (req_primary)
         PRI_YELLOW:  base = 0;
         PRI_MAGENTA: base = COLUMNS;
         default:     base = 2 * COLUMNS;
      endcase
      rd_addr  = ADDR_W'(base + int'(req_column));
      mod_prod = 23'(req_row) * 23'(MOD_MUL);
      mod_quot = mod_prod[22:MOD_SHIFT];
      mod_rem  = req_row - 11'(11'(mod_quot) * 11'(BAND_PERIOD));
      mod_fix  = (mod_rem >= 11'(BAND_PERIOD)) ? mod_rem - 11'(BAND_PERIOD) : mod_rem;
   end

   // stage registers
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_skip_ff;
   logic [1:0]        s1_pri_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [9:0]        s1_col_ff;
   logic [7:0]        s1_int_ff;
   logic [4:0]        s1_bpos_ff;
   logic [10:0]       s1_len_ff;
   logic [ERR_W-1:0]  run_ff [3];

   logic                     band_row;
   logic                     advance;
   logic [ERR_W-1:0]         run_err;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  adj;
   logic signed [SUM_W-1:0]  half;
   logic                     dot;
   logic [BAND_W-1:0]        band_or;
   logic                     line_end;
   logic                     first_col;

   always_comb begin
      band_row = (s1_bpos_ff == 5'd0);
      advance  = s1_valid_ff && (s1_skip_ff || !band_row || emit_free);
      hold     = s1_valid_ff && !advance;

      case (s1_pri_ff)
         PRI_YELLOW:  run_err = run_ff[0];
         PRI_MAGENTA: run_err = run_ff[1];
         default:     run_err = run_ff[2];
      endcase

      sum  = SUM_W'($signed(run_err)) + $signed({3'b000, s1_int_ff})
         + SUM_W'($signed(rd_err));
      dot  = (sum < SUM_W'(THRESHOLD));
      adj  = dot ? sum : sum - SUM_W'(FULL_SCALE);
      half = (adj + SUM_W'({{(SUM_W-1){1'b0}}, adj[SUM_W-1]})) >>> 1;

      band_or = rd_band | (BAND_W'(dot) << s1_bpos_ff);

      wr.en   = advance && !s1_skip_ff;
      wr.addr = s1_addr_ff;
      wr.err  = half[ERR_W-1:0];
      wr.band = band_row ? {band_or[0], {(BAND_W-1){1'b0}}} : band_or;

      first_col = (s1_col_ff == 10'd0);
      line_end  = (s1_len_ff != 11'd0) && ({1'b0, s1_col_ff} == s1_len_ff - 11'd1);

      emit_load            = advance && !s1_skip_ff && band_row;
      emit_data.len        = s1_len_ff;
      emit_data.band       = band_or;
      emit_data.mask       = '0;
      emit_data.mask[SEQ_INIT_ESC] = first_col && (s1_pri_ff == PRI_YELLOW);
      emit_data.mask[SEQ_INIT_EM]  = first_col && (s1_pri_ff == PRI_YELLOW);
      emit_data.mask[SEQ_GFX_ESC]  = first_col;
      emit_data.mask[SEQ_GFX_PCT]  = first_col;
      emit_data.mask[SEQ_GFX_O]    = first_col;
      emit_data.mask[SEQ_LEN_LO]   = first_col;
      emit_data.mask[SEQ_LEN_HI]   = first_col;
      emit_data.mask[SEQ_BAND_HI]  = 1'b1;
      emit_data.mask[SEQ_BAND_MID] = 1'b1;
      emit_data.mask[SEQ_BAND_LO]  = 1'b1;
      emit_data.mask[SEQ_CR]       = line_end;
      emit_data.mask[SEQ_LF]       = line_end && (s1_pri_ff == PRI_CYAN);

      s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         run_ff[0]   <= '0;
         run_ff[1]   <= '0;
         run_ff[2]   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (wr.en) begin
            case (s1_pri_ff)
               PRI_YELLOW:  run_ff[0] <= wr.err;
               PRI_MAGENTA: run_ff[1] <= wr.err;
               default:     run_ff[2] <= wr.err;
            endcase
         end
      end
      if (req_accept) begin
         s1_skip_ff <= req_skip;
         s1_pri_ff  <= req_primary;
         s1_addr_ff <= rd_addr;
         s1_col_ff  <= req_column;
         s1_int_ff  <= req_intensity;
         s1_bpos_ff <= mod_fix[4:0];
         s1_len_ff  <= req_line_length;
      end
   end

endmodule

/* rtl/dbpe_emit.sv */
module dbpe_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  dbpe_pkg::emit_load_type  load_data,
   input  logic                     rsp_stall,
   output logic                     free,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last
);
   import dbpe_pkg::*;

   logic               valid_ff, valid_in;
   logic [SEQ_LEN-1:0] rem_ff, rem_in;
   logic [10:0]        len_ff;
   logic [BAND_W-1:0]  band_ff;

   logic [3:0]         pos;
   logic [SEQ_LEN-1:0] low_bit;
   logic               accept;

   always_comb begin
      pos = '0;
      for (int i = SEQ_LEN - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            pos = 4'(i);
         end
      end
      low_bit  = rem_ff & (~rem_ff + 1'b1);
      rsp_last = ((rem_ff & (rem_ff - 1'b1)) == '0);
      accept   = valid_ff && !rsp_stall;
      free     = !valid_ff || (accept && rsp_last);

      unique case (pos)
         SEQ_INIT_ESC: rsp_out_byte = BYTE_ESC;
         SEQ_INIT_EM:  rsp_out_byte = BYTE_EM;
         SEQ_GFX_ESC:  rsp_out_byte = BYTE_ESC;
         SEQ_GFX_PCT:  rsp_out_byte = BYTE_PCT;
         SEQ_GFX_O:    rsp_out_byte = BYTE_O;
         SEQ_LEN_LO:   rsp_out_byte = len_ff[7:0];
         SEQ_LEN_HI:   rsp_out_byte = {5'b00000, len_ff[10:8]};
         SEQ_BAND_HI:  rsp_out_byte = band_ff[23:16];
         SEQ_BAND_MID: rsp_out_byte = band_ff[15:8];
         SEQ_BAND_LO:  rsp_out_byte = band_ff[7:0];
         SEQ_CR:       rsp_out_byte = BYTE_CR;
         SEQ_LF:       rsp_out_byte = BYTE_LF;
         default:      rsp_out_byte = 8'h00;
      endcase

      valid_in = valid_ff;
      rem_in   = rem_ff;
      if (load) begin
         valid_in = 1'b1;
         rem_in   = load_data.mask;
      end else if (accept) begin
         rem_in = rem_ff & ~low_bit;
         if (rsp_last) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
      if (load) begin
         len_ff  <= load_data.len;
         band_ff <= load_data.band;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* rtl/dither_band_printer_encoder.sv */
// error-diffusion halftoner and band printer encoder
//
// req channel: one colour sample per request (primary, column, intensity,
// row, line_length), taken when req_valid is high and req_stall is low.
// rsp channel: printer bytes, one per transfer, with rsp_last on the final
// byte caused by a request. Requests on non-band rows and ignored requests
// produce no bytes.
// a band-row request's first byte appears once it has passed the diffusion
// and emit registers. non-band rows sustain one request per cycle while
// req_stall is low. a band-row request puts 3 to 11 bytes on the output;
// the next is taken while the bytes drain and waits in the diffusion stage.
// per-column error and band words share one 33-bit memory with a read and
// a write port, read at accept and written back as the request leaves the
// diffusion stage, with the last write forwarded to a read of that entry.
// after reset the memory is cleared, one entry a cycle, through all 3072
// entries, during which req_stall is high.
// while rsp_stall is high the current byte holds; once a band-row request
// waits in the diffusion stage, req_stall rises.
module dither_band_printer_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_primary,
   input  logic [9:0]  req_column,
   input  logic [7:0]  req_intensity,
   input  logic [10:0] req_row,
   input  logic [10:0] req_line_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);
   import dbpe_pkg::*;

   logic              req_accept;
   logic              store_ready;
   logic              hold;
   logic              emit_free;
   logic              emit_load;
   logic [ADDR_W-1:0] rd_addr;
   logic [ERR_W-1:0]  rd_err;
   logic [BAND_W-1:0] rd_band;
   store_write_type   wr;
   emit_load_type     emit_data;

   assign req_stall  = !store_ready || hold;
   assign req_accept = req_valid && !req_stall;

   dbpe_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .wr      (wr),
      .ready   (store_ready),
      .rd_err  (rd_err),
      .rd_band (rd_band)
   );

   dbpe_diffuse u_diffuse (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_primary     (req_primary),
      .req_column      (req_column),
      .req_intensity   (req_intensity),
      .req_row         (req_row),
      .req_line_length (req_line_length),
      .rd_err          (rd_err),
      .rd_band         (rd_band),
      .emit_free       (emit_free),
      .rd_addr         (rd_addr),
      .hold            (hold),
      .wr              (wr),
      .emit_load       (emit_load),
      .emit_data       (emit_data)
   );

   dbpe_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (emit_load),
      .load_data    (emit_data),
      .rsp_stall    (rsp_stall),
      .free         (emit_free),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dbpe_pkg::*;

   localparam logic [1:0] PRI_NONE = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } print_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_primary;
   logic [9:0]  req_column;
   logic [7:0]  req_intensity;
   logic [10:0] req_row;
   logic [10:0] req_line_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;

   print_byte_type    expected_bytes[$];
   int                run_err[3];
   int                col_err[ENTRIES];
   logic [BAND_W-1:0] band_word[ENTRIES];

   dither_band_printer_encoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_primary(req_primary),
      .req_column(req_column),
      .req_intensity(req_intensity),
      .req_row(req_row),
      .req_line_length(req_line_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch on %s: got %02h, expected %02h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // halftone one request and queue the printer bytes it causes
   function automatic void predict_sample(input logic [1:0] p, input logic [9:0] col,
                                          input logic [7:0] level, input logic [10:0] row,
                                          input logic [10:0] len);
      int                idx;
      int                acc;
      int                phase;
      logic              dot;
      logic [BAND_W-1:0] word;
      logic [7:0]        burst[$];
      if (p > PRI_CYAN || int'(col) >= COLUMNS || int'(row) >= ROW_LIMIT)
         return;
      idx = int'(p) * COLUMNS + int'(col);
      acc = run_err[p] + int'(level) + col_err[idx];
      dot = acc < THRESHOLD;
      if (!dot)
         acc -= FULL_SCALE;
      acc = acc / 2;
      run_err[p] = acc;
      col_err[idx] = acc;
      phase = int'(row) % BAND_PERIOD;
      if (phase != 0) begin
         band_word[idx] = band_word[idx] | (BAND_W'(dot) << phase);
         return;
      end
      if (col == 0) begin
         if (p == PRI_YELLOW) begin
            burst.push_back(BYTE_ESC);
            burst.push_back(BYTE_EM);
         end
         burst.push_back(BYTE_ESC);
         burst.push_back(BYTE_PCT);
         burst.push_back(BYTE_O);
         burst.push_back(len[7:0]);
         burst.push_back({5'b0, len[10:8]});
      end
      word = band_word[idx] | BAND_W'(dot);
      band_word[idx] = {word[0], {(BAND_W-1){1'b0}}};
      burst.push_back(word[23:16]);
      burst.push_back(word[15:8]);
      burst.push_back(word[7:0]);
      if (len != 0 && int'(col) == int'(len) - 1) begin
         burst.push_back(BYTE_CR);
         if (p == PRI_CYAN)
            burst.push_back(BYTE_LF);
      end
      foreach (burst[i])
         expected_bytes.push_back('{burst[i], i == burst.size() - 1});
   endfunction

   task automatic send_sample(input logic [1:0] p, input logic [9:0] col,
                              input logic [7:0] level, input logic [10:0] row,
                              input logic [10:0] len);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_primary <= p;
      req_column <= col;
      req_intensity <= level;
      req_row <= row;
      req_line_length <= len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_sample(p, col, level, row, len);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // receiver side
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      print_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("byte with none expected", rsp_out_byte, 8'h00);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch("out_byte", rsp_out_byte, want.data);
            if (rsp_last !== want.last)
               report_mismatch("last", {7'b0, rsp_last}, {7'b0, want.last});
         end
      end
   end

   // one bit row then one band row, two columns, all primaries
   task automatic test_band_rows();
      for (int r = 1; r >= 0; r--)
         for (int p = 0; p < 3; p++)
            for (int c = 0; c < 2; c++)
               send_sample(2'(p), 10'(c), ((p + c + r) % 2) ? 8'd255 : 8'd0, 11'(r),
                           11'd2);
   endtask

   task automatic test_special_cases();
      send_sample(PRI_NONE, 10'd0, 8'd0, 11'd0, 11'd2);
      send_sample(PRI_CYAN, 10'd1023, 8'd255, 11'd2047, 11'd1024);
      send_sample(PRI_MAGENTA, 10'd0, 8'd0, 11'd0, 11'd0);
      send_sample(PRI_YELLOW, 10'd0, 8'd128, 11'd0, 11'd2047);
      send_sample(PRI_MAGENTA, 10'd5, 8'd127, 11'd46, 11'd2);
      send_sample(PRI_YELLOW, 10'd1023, 8'd255, 11'd22, 11'd1024);
      send_sample(PRI_YELLOW, 10'd1023, 8'd127, 11'd0, 11'd1024);
      send_sample(PRI_NONE, 10'd1023, 8'd255, 11'd2047, 11'd2047);
   endtask

   // sender holds off until the output has fully drained
   task automatic test_drain_pause();
      send_sample(PRI_CYAN, 10'd0, 8'd64, 11'd23, 11'd1);
      wait_drained();
      send_sample(PRI_CYAN, 10'd0, 8'd200, 11'd23, 11'd1);
      wait_drained();
   endtask

   task automatic send_noise();
      send_sample(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                  8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                  11'($urandom_range(0, 2047)));
   endtask

   // rows sweeping down into a band row, with noise and cut-off frames mixed in
   task automatic test_random_frames(input int idle, input int stall);
      int          count;
      int          cols;
      int          base;
      int          top;
      logic [10:0] len;
      bit          cut;
      send_idle_pct = idle;
      stall_pct = stall;
      count = 0;
      while (count < 20) begin
         cols = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
         base = 23 * $urandom_range(0, 88);
         top = base + $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0: len = 11'd0;
            1: len = 11'(cols + $urandom_range(1, 3));
            default: len = 11'(cols);
         endcase
         cut = 1'b0;
         for (int r = top; r >= base && !cut; r--)
            for (int p = 0; p < 3 && !cut; p++)
               for (int c = 0; c < cols && !cut; c++) begin
                  if ($urandom_range(0, 9) == 0) begin
                     send_noise();
                     count++;
                  end
                  if ($urandom_range(0, 39) == 0 || count >= 20)
                     cut = 1'b1;
                  else begin
                     send_sample(2'(p), 10'(c), 8'($urandom_range(0, 255)), 11'(r), len);
                     count++;
                  end
               end
      end
   endtask

   initial begin
      foreach (band_word[i])
         band_word[i] = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_primary <= '0;
      req_column <= '0;
      req_intensity <= '0;
      req_row <= '0;
      req_line_length <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_band_rows();
      test_special_cases();
      test_drain_pause();
      test_random_frames(0, 0);
      test_random_frames(64, 0);
      test_random_frames(0, 64);
      test_random_frames(7, 7);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
rtl/dbpe_pkg.sv
rtl/dbpe_store.sv
rtl/dbpe_diffuse.sv
rtl/dbpe_emit.sv
rtl/dither_band_printer_encoder.sv
verif/testbench.sv
